@@ rtl/erm_pkg.sv @@
// shared constants, types and tables of the euler rotation matrix core
// no dependencies
package erm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ITERS = 30;
	localparam int ANGLE_W = 16;
	localparam int AXIS_W = 2;
	localparam int OUT_W = 18;
	localparam int FIFO_DEPTH_DEF = 4;
	localparam logic [63:0] K32 = 64'h9B74EDA8;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	function automatic logic [31:0] atan_val(input int n);
		logic [31:0] v;
		case (n)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/erm_cordic.sv @@
// pipelined rotation-mode cordic, one angle to cosine and sine
// depends on erm_pkg
module erm_cordic #(
	parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [erm_pkg::ANGLE_W-1:0]  angle,
	output logic signed [FRAC_BITS+1:0]         cos_o,
	output logic signed [FRAC_BITS+1:0]         sin_o
);
	import erm_pkg::*;

	localparam int W = FRAC_BITS + 2;
	localparam int SH = 32 - W;
	localparam int XW = W + 3;
	localparam int ZW = 33;
	localparam logic [63:0] KX =
		(K32 + ((SH == 0) ? 64'd0 : (64'd1 << ((SH == 0) ? 0 : SH - 1)))) >> SH;
	localparam logic signed [XW:0] ONE_X = (XW+1)'(1) << FRAC_BITS;

	logic signed [XW-1:0] x_s [0:ITERS];
	logic signed [XW-1:0] y_s [0:ITERS];
	logic signed [ZW-1:0] z_s [0:ITERS];
	logic                 neg_s [0:ITERS];

	logic signed [ZW-1:0] z_in;
	logic signed [XW:0]   xv, yv, xr, yr;

	always_comb begin
		z_in = ZW'($signed({angle, 16'b0}));
		if (angle > 16'sd16384) begin
			z_in = z_in - (ZW'(1) << 31);
		end else if (angle < -16'sd16384) begin
			z_in = z_in + (ZW'(1) << 31);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= XW'(KX);
			y_s[0] <= '0;
			z_s[0] <= z_in;
			neg_s[0] <= (angle > 16'sd16384) || (angle < -16'sd16384);
		end
	end

	for (genvar n = 0; n < ITERS; n++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[n+1] <= neg_s[n];
				if (z_s[n] >= 0) begin
					x_s[n+1] <= x_s[n] - (y_s[n] >>> n);
					y_s[n+1] <= y_s[n] + (x_s[n] >>> n);
					z_s[n+1] <= z_s[n] - ZW'(atan_val(n));
				end else begin
					x_s[n+1] <= x_s[n] + (y_s[n] >>> n);
					y_s[n+1] <= y_s[n] - (x_s[n] >>> n);
					z_s[n+1] <= z_s[n] + ZW'(atan_val(n));
				end
			end
		end
	end

	always_comb begin
		xv = neg_s[ITERS] ? -(XW+1)'(x_s[ITERS]) : (XW+1)'(x_s[ITERS]);
		yv = neg_s[ITERS] ? -(XW+1)'(y_s[ITERS]) : (XW+1)'(y_s[ITERS]);
		xr = (xv + (XW+1)'(2)) >>> 2;
		yr = (yv + (XW+1)'(2)) >>> 2;
		if (xr > ONE_X) xr = ONE_X;
		else if (xr < -ONE_X) xr = -ONE_X;
		if (yr > ONE_X) yr = ONE_X;
		else if (yr < -ONE_X) yr = -ONE_X;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= xr[W-1:0];
			sin_o <= yr[W-1:0];
		end
	end

endmodule

@@ rtl/erm_front.sv @@
// front end: accepts items, classifies skipped steps, runs three cordics
// depends on erm_pkg and erm_cordic
module erm_front #(
	parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [3*erm_pkg::ANGLE_W-1:0]      angles,
	input  logic [3*erm_pkg::AXIS_W-1:0]       axes,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [3*(2*FRAC_BITS+7)-1:0]       steps
);
	import erm_pkg::*;

	localparam int EW = FRAC_BITS + 2;
	localparam int SW = 2 * EW + 3;
	localparam int LAT = ITERS + 2;

	logic en;
	logic vld_s [0:LAT-1];
	logic [AXIS_W-1:0] axis_s [0:2][0:LAT-1];
	logic skip_s [0:2][0:LAT-1];
	logic signed [EW-1:0] c_w [0:2];
	logic signed [EW-1:0] s_w [0:2];

	assign out_valid = vld_s[LAT-1];
	assign en = !vld_s[LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_ang
		erm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
			.clk   (clk),
			.en    (en),
			.angle (angles[k*ANGLE_W +: ANGLE_W]),
			.cos_o (c_w[k]),
			.sin_o (s_w[k])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				axis_s[k][0] <= axes[k*AXIS_W +: AXIS_W];
				skip_s[k][0] <= (angles[k*ANGLE_W +: ANGLE_W] == '0) ||
					(axis_t'(axes[k*AXIS_W +: AXIS_W]) == AXIS_NONE);
				for (int i = 1; i < LAT; i++) begin
					axis_s[k][i] <= axis_s[k][i-1];
					skip_s[k][i] <= skip_s[k][i-1];
				end
			end
		end

		assign steps[k*SW +: SW] = {skip_s[k][LAT-1], axis_s[k][LAT-1], s_w[k], c_w[k]};
	end

endmodule

@@ rtl/erm_fifo.sv @@
// short queue between front and back ends
// depends on erm_pkg
module erm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = erm_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import erm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

@@ rtl/erm_rotate.sv @@
// one elementary rotation: post-multiply the matrix, two pipeline stages
// depends on erm_pkg
module erm_rotate #(
	parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF,
	parameter int STEP = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [9*(FRAC_BITS+2)-1:0]       m_in,
	input  logic [3*(2*FRAC_BITS+7)-1:0]     par_in,
	output logic [9*(FRAC_BITS+2)-1:0]       m_out,
	output logic [3*(2*FRAC_BITS+7)-1:0]     par_out
);
	import erm_pkg::*;

	localparam int EW = FRAC_BITS + 2;
	localparam int SW = 2 * EW + 3;
	localparam int PW = 2 * EW;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW:0] ONE_P = (PW+1)'(1) << FRAC_BITS;

	logic [SW-1:0] par;
	logic signed [EW-1:0] c, s;
	logic [1:0] a, b;
	logic signed [EW-1:0] me [0:8];
	logic signed [EW-1:0] p [0:2];
	logic signed [EW-1:0] q [0:2];

	logic [9*EW-1:0] m_s1;
	logic [3*SW-1:0] par_s1;
	logic [1:0] a_s1, b_s1;
	logic skip_s1;
	logic signed [PW-1:0] pc_s1 [0:2];
	logic signed [PW-1:0] qs_s1 [0:2];
	logic signed [PW-1:0] ps_s1 [0:2];
	logic signed [PW-1:0] qc_s1 [0:2];

	logic signed [PW:0] na, nb;
	logic [9*EW-1:0] m_nx;

	assign par = par_in[STEP*SW +: SW];
	assign c = par[EW-1:0];
	assign s = par[2*EW-1:EW];

	always_comb begin
		case (axis_t'(par[2*EW+1:2*EW]))
			AXIS_X: begin a = 2'd1; b = 2'd2; end
			AXIS_Y: begin a = 2'd2; b = 2'd0; end
			AXIS_Z: begin a = 2'd0; b = 2'd1; end
			default: begin a = 2'd0; b = 2'd1; end
		endcase
		for (int i = 0; i < 9; i++) me[i] = m_in[i*EW +: EW];
		for (int i = 0; i < 3; i++) begin
			p[i] = me[i*3 + int'(a)];
			q[i] = me[i*3 + int'(b)];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= m_in;
			par_s1 <= par_in;
			a_s1 <= a;
			b_s1 <= b;
			skip_s1 <= par[2*EW+2];
			for (int i = 0; i < 3; i++) begin
				pc_s1[i] <= p[i] * c;
				qs_s1[i] <= q[i] * s;
				ps_s1[i] <= p[i] * s;
				qc_s1[i] <= q[i] * c;
			end
		end
	end

	always_comb begin
		m_nx = m_s1;
		na = '0;
		nb = '0;
		for (int i = 0; i < 3; i++) begin
			na = ((PW+1)'(pc_s1[i]) + (PW+1)'(qs_s1[i]) + HALF) >>> FRAC_BITS;
			nb = ((PW+1)'(qc_s1[i]) - (PW+1)'(ps_s1[i]) + HALF) >>> FRAC_BITS;
			if (na > ONE_P) na = ONE_P;
			else if (na < -ONE_P) na = -ONE_P;
			if (nb > ONE_P) nb = ONE_P;
			else if (nb < -ONE_P) nb = -ONE_P;
			if (!skip_s1) begin
				m_nx[(i*3 + int'(a_s1))*EW +: EW] = na[EW-1:0];
				m_nx[(i*3 + int'(b_s1))*EW +: EW] = nb[EW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_out <= m_nx;
			par_out <= par_s1;
		end
	end

endmodule

@@ rtl/erm_back.sv @@
// back end: pulls sine and cosine sets from the queue, applies three rotations
// depends on erm_pkg and erm_rotate
module erm_back #(
	parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [3*(2*FRAC_BITS+7)-1:0]    steps,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [9*(FRAC_BITS+2)-1:0]      matrix
);
	import erm_pkg::*;

	localparam int EW = FRAC_BITS + 2;
	localparam int SW = 2 * EW + 3;
	localparam int LAT = 6;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [9*EW-1:0] ident;
	logic [9*EW-1:0] m_w [0:3];
	logic [3*SW-1:0] p_w [0:3];

	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_comb begin
		ident = '0;
		for (int i = 0; i < 3; i++) ident[(i*4)*EW +: EW] = EW'(1) << FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign m_w[0] = ident;
	assign p_w[0] = steps;

	for (genvar k = 0; k < 3; k++) begin : g_rot
		erm_rotate #(.FRAC_BITS(FRAC_BITS), .STEP(k)) u_rot (
			.clk     (clk),
			.en      (en),
			.m_in    (m_w[k]),
			.par_in  (p_w[k]),
			.m_out   (m_w[k+1]),
			.par_out (p_w[k+1])
		);
	end

	assign matrix = m_w[3];

endmodule

@@ rtl/euler_rotation_matrix_core.sv @@
// top level of the euler rotation matrix core
// depends on erm_pkg, erm_front, erm_fifo and erm_back
//
// usage: each item on the slave stream holds three binary angles and three
// axis codes; the core returns one 3x3 rotation matrix per item on the
// master stream, nine Q1.FRAC_BITS elements, row-major, 18 bits each.
// a step whose angle or axis code is zero leaves the matrix unchanged.
// with no stall, an accepted item passes through the 32 front cordic
// stages (input fold, one per cordic iteration, output rounding), then
// the queue write, then the back end, which for each rotation holds a
// product stage and then a sum, round and saturate stage. one item per
// cycle is sustained while m_tready stays high, set by the fully
// pipelined cordic and rotation stages.
// a stalled receiver freezes the back end; a FIFO_DEPTH-entry queue (four
// by default) then absorbs the front end's output before s_tready drops.
// reset clears all valid flags and the queue; no item is pending after it.
module euler_rotation_matrix_core #(
	parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF,
	parameter int FIFO_DEPTH = erm_pkg::FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// angle_first, angle_second, angle_third, axis_first, axis_second, axis_third
	input  logic [55:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic [167:0] m_tdata
);
	import erm_pkg::*;

	localparam int EW = FRAC_BITS + 2;
	localparam int SW = 2 * EW + 3;

	logic f_valid, f_ready, b_valid, b_ready;
	logic [3*SW-1:0] f_steps, b_steps;
	logic [9*EW-1:0] matrix;
	logic signed [63:0] e64 [0:8];

	erm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.angles    (s_tdata[3*ANGLE_W-1:0]),
		.axes      (s_tdata[3*ANGLE_W +: 3*AXIS_W]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.steps     (f_steps)
	);

	erm_fifo #(.WIDTH(3*SW), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_steps),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_steps)
	);

	erm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.steps     (b_steps),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.matrix    (matrix)
	);

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 9; i++) begin
			e64[i] = 64'($signed(matrix[i*EW +: EW]));
			m_tdata[i*OUT_W +: OUT_W] = e64[i][OUT_W-1:0];
		end
	end

endmodule
